/* hw/rtl/dwsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dwsm_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int SPEED_WIDTH_DEF   = 8;

    localparam int DEB_W      = 16;
    localparam int DIST_W     = 20;
    localparam int RATE_W     = 16;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = CFG_IDX_W'(3);

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(10);
    localparam logic [DIST_W-1:0] DISTANCE_RST = DIST_W'(31415);
    localparam logic [RATE_W-1:0] RATE_RST     = RATE_W'(8000);
    localparam logic [DIV_W-1:0]  DIVISOR_RST  = DIV_W'(17600);

    typedef struct packed {
        logic [DEB_W-1:0]  debounce;
        logic [DIST_W-1:0] distance;
        logic [RATE_W-1:0] rate;
        logic [DIV_W-1:0]  divisor;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic upd;
    } t_lane_stat;

endpackage

`default_nettype wire

/* hw/rtl/dwsm_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dwsm_in_if;
    logic valid;
    logic ready;
    logic left_level;
    logic right_level;

    modport source (output valid, output left_level, output right_level, input ready);
    modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

interface dwsm_out_if import dwsm_pkg::*; #(
    parameter int SW = SPEED_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] speed_left;
    logic [SW-1:0] speed_right;
    logic          left_updated;
    logic          right_updated;

    modport source (output valid, output speed_left, output speed_right,
                    output left_updated, output right_updated, input ready);
    modport sink   (input valid, input speed_left, input speed_right,
                    input left_updated, input right_updated, output ready);
endinterface

interface dwsm_cfg_if import dwsm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dwsm_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwsm_div #(
    parameter int NW = 20,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    // restoring division, one quotient bit a cycle; numerator shifts out as quotient shifts in
    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

/* hw/rtl/dwsm_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwsm_lane import dwsm_pkg::*; #(
    parameter int CW = COUNTER_WIDTH_DEF,
    parameter int SW = SPEED_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_level,
    input  wire logic i_take,
    input  wire t_cfg i_cfg,
    output t_lane_stat    o_stat,
    output logic [SW-1:0] o_speed
);

    localparam int CMP_W  = (CW > DEB_W) ? CW : DEB_W;
    localparam int PROD_W = DIST_W + RATE_W;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV1 = 2'd1;
    localparam logic [1:0] PH_MUL  = 2'd2;
    localparam logic [1:0] PH_DIV2 = 2'd3;

    logic [1:0]    r_phase;
    logic          r_done;
    logic          r_upd;
    logic [CW-1:0] r_period;
    logic [CW-1:0] r_deb;
    logic          r_active;
    logic [SW-1:0] r_hold;
    logic [PROD_W-1:0] r_prod;

    logic [CW-1:0]     p1;
    logic [CW-1:0]     d1;
    logic              deb_gt;
    logic              rise;
    logic              fall;
    logic              div1_start;
    logic              div1_done;
    logic [DIST_W-1:0] div1_quo;
    logic              div2_start;
    logic              div2_done;
    logic [PROD_W-1:0] div2_quo;

    // saturating increments
    assign p1 = (r_period == '1) ? r_period : r_period + 1'b1;
    assign d1 = (r_deb == '1) ? r_deb : r_deb + 1'b1;

    assign deb_gt = (CMP_W)'(d1) > (CMP_W)'(i_cfg.debounce);
    assign rise   = i_level && !r_active && deb_gt;
    assign fall   = !i_level && r_active && deb_gt;

    assign div1_start = i_start && rise && (r_phase == PH_IDLE);
    assign div2_start = (r_phase == PH_MUL);

    dwsm_div #(
        .NW (DIST_W),
        .DW (CW)
    ) u_div_period (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div1_start),
        .i_num   (i_cfg.distance),
        .i_den   (p1),
        .o_done  (div1_done),
        .o_quo   (div1_quo)
    );

    // a zero divisor yields an all-ones quotient, which the lane saturates to the largest speed
    dwsm_div #(
        .NW (PROD_W),
        .DW (DIV_W)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div2_start),
        .i_num   (r_prod),
        .i_den   (i_cfg.divisor),
        .o_done  (div2_done),
        .o_quo   (div2_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_done   <= 1'b0;
            r_upd    <= 1'b0;
            r_period <= '0;
            r_deb    <= '0;
            r_active <= 1'b0;
            r_hold   <= '0;
        end else begin
            if (i_take) begin
                r_done <= 1'b0;
            end
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        if (rise) begin
                            r_active <= 1'b1;
                            r_period <= '0;
                            r_deb    <= '0;
                            r_upd    <= 1'b1;
                            r_phase  <= PH_DIV1;
                        end else begin
                            r_period <= p1;
                            r_deb    <= fall ? '0 : d1;
                            if (fall) begin
                                r_active <= 1'b0;
                            end
                            r_upd  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                PH_DIV1: begin
                    if (div1_done) begin
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_phase <= PH_DIV2;
                end
                PH_DIV2: begin
                    if (div2_done) begin
                        if (div2_quo > PROD_W'({SW{1'b1}})) begin
                            r_hold <= '1;
                        end else begin
                            r_hold <= div2_quo[SW-1:0];
                        end
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_DIV1 && div1_done) begin
            r_prod <= PROD_W'(div1_quo) * PROD_W'(i_cfg.rate);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.upd  = r_upd;
    assign o_speed     = r_hold;

endmodule

`default_nettype wire

/* hw/rtl/dwsm_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwsm_merge import dwsm_pkg::*; #(
    parameter int SW = SPEED_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_lane_stat    i_left,
    input  wire t_lane_stat    i_right,
    input  wire logic [SW-1:0] i_speed_left,
    input  wire logic [SW-1:0] i_speed_right,
    dwsm_out_if.source         o_out,
    output logic               o_take
);

    logic          r_valid;
    logic [SW-1:0] r_speed_left;
    logic [SW-1:0] r_speed_right;
    logic          r_upd_left;
    logic          r_upd_right;

    // both lanes finished and the output register is free or emptying
    assign o_take = i_left.done && i_right.done && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_speed_left  <= i_speed_left;
            r_speed_right <= i_speed_right;
            r_upd_left    <= i_left.upd;
            r_upd_right   <= i_right.upd;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.speed_left    = r_speed_left;
    assign o_out.speed_right   = r_speed_right;
    assign o_out.left_updated  = r_upd_left;
    assign o_out.right_updated = r_upd_right;

endmodule

`default_nettype wire

/* hw/rtl/dual_wheel_speed_meter.sv */
// dual wheel speed meter
// i_in carries one sample tick per item with the left and right sensor levels.
// o_out returns exactly one item per tick: both held speeds and a flag per wheel
// that is set when that tick accepted a rising edge and produced a new speed.
// i_cfg writes the four registers (debounce, distance per pulse, sample rate,
// speed divisor) by index; it is always ready and should only be used while idle.
// Each wheel has its own lane with period and debounce counters and two serial
// dividers; the lanes run side by side and a merge stage builds the result item.
// A tick with no accepted rising edge sets the lane done flags when it is accepted;
// the merge then moves the result into the output register and frees the block.
// A tick with a rising edge on either wheel runs through the lane's phases in order:
// a bit-serial division of distance by period over its 20 quotient bits, a multiply
// by the sample rate, a bit-serial division of the 36-bit product by the divisor,
// then a write of the held speed, before the merge fills the output register.
// One tick is in flight at a time; the next is accepted as soon as the previous
// result has moved into the output register, even if it has not been taken yet.
// When the receiver stalls, the result holds in o_out and the finished lanes wait.
// Synchronous active-low reset clears counters, pulse flags, held speeds and
// restores register defaults 10, 31415, 8000 and 17600.
`timescale 1ns / 1ps
`default_nettype none

module dual_wheel_speed_meter import dwsm_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
    parameter int SPEED_WIDTH   = SPEED_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dwsm_in_if.sink    i_in,
    dwsm_cfg_if.sink   i_cfg,
    dwsm_out_if.source o_out
);

    t_cfg r_cfg;
    logic r_busy;

    logic                   start;
    logic                   take;
    t_lane_stat             stat_left;
    t_lane_stat             stat_right;
    logic [SPEED_WIDTH-1:0] speed_left;
    logic [SPEED_WIDTH-1:0] speed_right;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_busy;
    assign start       = i_in.valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RST;
            r_cfg.distance <= DISTANCE_RST;
            r_cfg.rate     <= RATE_RST;
            r_cfg.divisor  <= DIVISOR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEBOUNCE: r_cfg.debounce <= i_cfg.data[DEB_W-1:0];
                REG_DISTANCE: r_cfg.distance <= i_cfg.data[DIST_W-1:0];
                REG_RATE:     r_cfg.rate     <= i_cfg.data[RATE_W-1:0];
                REG_DIVISOR:  r_cfg.divisor  <= i_cfg.data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // busy from item acceptance until the merge stage has taken both lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= 1'b1;
        end else if (take) begin
            r_busy <= 1'b0;
        end
    end

    dwsm_lane #(
        .CW (COUNTER_WIDTH),
        .SW (SPEED_WIDTH)
    ) u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_level (i_in.left_level),
        .i_take  (take),
        .i_cfg   (r_cfg),
        .o_stat  (stat_left),
        .o_speed (speed_left)
    );

    dwsm_lane #(
        .CW (COUNTER_WIDTH),
        .SW (SPEED_WIDTH)
    ) u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_level (i_in.right_level),
        .i_take  (take),
        .i_cfg   (r_cfg),
        .o_stat  (stat_right),
        .o_speed (speed_right)
    );

    dwsm_merge #(
        .SW (SPEED_WIDTH)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_left        (stat_left),
        .i_right       (stat_right),
        .i_speed_left  (speed_left),
        .i_speed_right (speed_right),
        .o_out         (o_out),
        .o_take        (take)
    );

`ifndef ASSERT_OFF
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_busy)
        else $error("accepted item did not mark the block busy");

    a_take_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_busy)
        else $error("merge took lane results with no item in flight");

    a_idle_lanes_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (!stat_left.done && !stat_right.done))
        else $error("lane result pending while block is idle");

    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (!r_busy && !stat_left.done && !stat_right.done && o_out.valid))
        else $error("merge did not hand the item to the output register");
`endif

endmodule

`default_nettype wire

/* dv/dwsm_speed_checker.sv */
`timescale 1ns / 1ps

module dwsm_speed_checker import dwsm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dwsm_in_if        in_mon,
    dwsm_cfg_if       cfg_mon,
    dwsm_out_if       out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int CW     = COUNTER_WIDTH_DEF;
    localparam int SW     = SPEED_WIDTH_DEF;
    localparam int PROD_W = DIST_W + RATE_W;

    typedef struct packed {
        logic [SW-1:0] speed_left;
        logic [SW-1:0] speed_right;
        logic          left_updated;
        logic          right_updated;
    } t_wheel_report;

    t_wheel_report expected_reports[$];
    t_cfg          regs;
    logic [CW-1:0] period_cnt   [2];
    logic [CW-1:0] debounce_cnt [2];
    logic          pulse_active [2];
    logic [SW-1:0] speed_hold   [2];

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [SW-1:0] speed_for_period(input logic [CW-1:0] period);
        logic [DIST_W-1:0] per_tick;
        logic [PROD_W-1:0] scaled;
        logic [PROD_W-1:0] quot;
        if (period == '0 || regs.divisor == '0) begin
            return '1;
        end
        per_tick = regs.distance / DIST_W'(period);
        scaled   = PROD_W'(per_tick) * PROD_W'(regs.rate);
        quot     = scaled / PROD_W'(regs.divisor);
        return (quot > PROD_W'({SW{1'b1}})) ? '1 : quot[SW-1:0];
    endfunction

    // advances one wheel by a tick, returns 1 when a rising edge was taken
    function automatic logic step_wheel(input int w, input logic level);
        period_cnt[w]   = bump(period_cnt[w]);
        debounce_cnt[w] = bump(debounce_cnt[w]);
        if (level && !pulse_active[w] && debounce_cnt[w] > regs.debounce) begin
            pulse_active[w] = 1'b1;
            speed_hold[w]   = speed_for_period(period_cnt[w]);
            period_cnt[w]   = '0;
            debounce_cnt[w] = '0;
            return 1'b1;
        end
        if (!level && pulse_active[w] && debounce_cnt[w] > regs.debounce) begin
            pulse_active[w] = 1'b0;
            debounce_cnt[w] = '0;
        end
        return 1'b0;
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_wheel_report fresh;
        t_wheel_report oldest;
        if (!i_rst_n) begin
            regs.debounce = DEBOUNCE_RST;
            regs.distance = DISTANCE_RST;
            regs.rate     = RATE_RST;
            regs.divisor  = DIVISOR_RST;
            for (int w = 0; w < 2; w++) begin
                period_cnt[w]   = '0;
                debounce_cnt[w] = '0;
                pulse_active[w] = 1'b0;
                speed_hold[w]   = '0;
            end
            expected_reports.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (out_mon.valid && out_mon.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result item with none expected, expected none, actual %0d %0d %0b %0b",
                             $time, out_mon.speed_left, out_mon.speed_right,
                             out_mon.left_updated, out_mon.right_updated);
                    o_fail_count++;
                end else begin
                    oldest = expected_reports.pop_front();
                    compare_field("speed_left", oldest.speed_left, out_mon.speed_left);
                    compare_field("speed_right", oldest.speed_right, out_mon.speed_right);
                    compare_field("left_updated", oldest.left_updated, out_mon.left_updated);
                    compare_field("right_updated", oldest.right_updated, out_mon.right_updated);
                end
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    REG_DEBOUNCE: regs.debounce = cfg_mon.data[DEB_W-1:0];
                    REG_DISTANCE: regs.distance = cfg_mon.data[DIST_W-1:0];
                    REG_RATE:     regs.rate     = cfg_mon.data[RATE_W-1:0];
                    REG_DIVISOR:  regs.divisor  = cfg_mon.data[DIV_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                fresh.left_updated  = step_wheel(0, in_mon.left_level);
                fresh.right_updated = step_wheel(1, in_mon.right_level);
                fresh.speed_left    = speed_hold[0];
                fresh.speed_right   = speed_hold[1];
                expected_reports.push_back(fresh);
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

/* dv/dual_wheel_speed_meter_tb.sv */
`timescale 1ns / 1ps

module dual_wheel_speed_meter_tb;
    import dwsm_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HIGH_HOLD_TICKS = 20;
    localparam int TRAIN_TICKS     = 72;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_DIVISOR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   rcv_idle_pct;
    bit   pressure_req;

    dwsm_in_if                               in_ch ();
    dwsm_cfg_if                              cfg_ch ();
    dwsm_out_if #(.SW(SPEED_WIDTH_DEF))      out_ch ();

    dual_wheel_speed_meter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    dwsm_speed_checker u_speed_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .cfg_mon      (cfg_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                pressure_req = 1'b0;
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no item moving on any channel
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_tick(input logic left_lvl, input logic right_lvl);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid       <= 1'b0;
            in_ch.left_level  <= 1'($urandom_range(1));
            in_ch.right_level <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_level  <= left_lvl;
        in_ch.right_level <= right_lvl;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DEB_W-1:0] thr, input logic [DIST_W-1:0] travel,
                                  input logic [RATE_W-1:0] rate, input logic [DIV_W-1:0] div);
        drain_results();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(thr));
        write_reg(REG_DISTANCE, CFG_DATA_W'(travel));
        write_reg(REG_RATE, CFG_DATA_W'(rate));
        write_reg(REG_DIVISOR, CFG_DATA_W'(div));
    endtask

    // square waves per wheel with run lengths around the debounce, some glitches mixed in
    task automatic run_pulse_train(input int n_ticks, input int thr);
        int   run_len [2];
        logic lvl     [2];
        logic bits    [2];
        for (int w = 0; w < 2; w++) begin
            run_len[w] = 0;
            lvl[w]     = 1'($urandom_range(1));
        end
        for (int i = 0; i < n_ticks; i++) begin
            for (int w = 0; w < 2; w++) begin
                if (run_len[w] == 0) begin
                    lvl[w]     = ~lvl[w];
                    run_len[w] = $urandom_range(thr + 4, 1);
                end
                run_len[w]--;
                bits[w] = ($urandom_range(99) < 15) ? 1'($urandom_range(1)) : lvl[w];
            end
            send_tick(bits[0], bits[1]);
        end
    endtask

    task automatic run_random_phase(input int src_pct, input int rcv_pct, input bit with_pressure);
        logic [DEB_W-1:0]  thr;
        logic [DIST_W-1:0] travel;
        logic [RATE_W-1:0] rate;
        logic [DIV_W-1:0]  div;
        drain_results();
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        for (int b = 0; b < 5; b++) begin
            case (b)
                0: begin
                    thr    = '0;
                    travel = DIST_W'(1000000);
                    rate   = '1;
                    div    = '1;
                end
                1: begin
                    thr    = DEB_W'($urandom_range(3));
                    travel = DIST_W'($urandom_range(3000, 1));
                    rate   = RATE_W'($urandom_range(65535, 1));
                    div    = DIV_W'($urandom_range(65535, 1));
                end
                2: begin
                    thr    = DEB_W'($urandom_range(24));
                    travel = DIST_W'($urandom_range(1000000, 1));
                    rate   = RATE_W'($urandom_range(65535, 1));
                    div    = DIV_W'($urandom_range(65535, 1));
                end
                3: begin
                    thr    = '0;
                    travel = DIST_W'($urandom_range(600, 1));
                    rate   = RATE_W'($urandom_range(4000, 1));
                    div    = DIV_W'($urandom_range(200, 1));
                end
                default: begin
                    thr    = DEB_W'(1);
                    travel = DIST_W'(1);
                    rate   = RATE_W'(1);
                    div    = DIV_W'(1);
                end
            endcase
            apply_settings(thr, travel, rate, div);
            if (with_pressure && b == 1) begin
                pressure_req = 1'b1;
            end
            run_pulse_train(TRAIN_TICKS, int'(thr));
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.left_level  <= 1'b0;
        in_ch.right_level <= 1'b0;
        out_ch.ready      <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        src_idle_pct = 35;
        rcv_idle_pct = 74;
        pressure_req = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: both wheels take their first edge once debounce has run out
        repeat (11) send_tick(1'b1, 1'b1);

        // speed far beyond range, every level combination
        apply_settings('0, DIST_W'(1000000), '1, DIV_W'(1));
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // zero distance, zero rate, zero divisor
        apply_settings('0, '0, RATE_RST, DIVISOR_RST);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        apply_settings('0, DISTANCE_RST, '0, DIVISOR_RST);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        apply_settings('0, DISTANCE_RST, RATE_RST, '0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // bits above the register width and unknown indexes must be dropped
        drain_results();
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(20'hF0002));
        write_reg(REG_UNUSED_LOW, '1);
        write_reg(REG_UNUSED_TOP, CFG_DATA_W'(20'h5A5A5));
        repeat (4) send_tick(1'b1, 1'b1);

        run_random_phase(35, 74, 1'b1);
        run_random_phase(74, 35, 1'b0);
        run_random_phase(0, 0, 1'b0);

        // largest debounce: park both wheels inactive, then hold the level high;
        // no edge is ever taken
        apply_settings('0, DIST_W'(1000000), RATE_W'(10), DIV_W'(1));
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        apply_settings('1, DIST_W'(1000000), RATE_W'(10), DIV_W'(1));
        repeat (HIGH_HOLD_TICKS) send_tick(1'b1, 1'b1);
        apply_settings(DEB_W'(16'hFFFE), DIST_W'(1000000), RATE_W'(10), DIV_W'(1));
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);

        drain_results();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
